// ----- src/tcfp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcfp_pkg - shared types and constants of the text cell format printer
// character codes, field widths and the control and status groups between
// the top level and the digit converter
// ----------------------------------------------------------------------------
package tcfp_pkg;

    localparam int ARG_W      = 32;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int OFFSET_W   = 23;
    localparam int POS_W      = 16;
    localparam int COLOUR_W   = 4;
    localparam int CHAR_W     = 8;

    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_PCT     = 8'h25;
    localparam logic [CHAR_W-1:0] CH_C       = 8'h63;
    localparam logic [CHAR_W-1:0] CH_H       = 8'h68;
    localparam logic [CHAR_W-1:0] CH_I       = 8'h69;
    localparam logic [CHAR_W-1:0] CH_S       = 8'h73;
    localparam logic [CHAR_W-1:0] CH_T       = 8'h74;
    localparam logic [CHAR_W-1:0] CH_B       = 8'h62;
    localparam logic [CHAR_W-1:0] CH_X       = 8'h78;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;

    localparam logic [POS_W-1:0]    WRAP_ROW = 16'd80;
    localparam logic [COLOUR_W-1:0] TEXT_RST = 4'hF;
    localparam logic [COLOUR_W-1:0] BACK_RST = 4'h0;

    typedef struct packed {
        logic start;
        logic hex;
        logic take;
    } t_conv_ctl;

    typedef struct packed {
        logic               valid;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } t_conv_st;

    function automatic logic [CHAR_W-1:0] f_glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] g;
        if (d < 4'd10) begin
            g = CH_ZERO + CHAR_W'(d);
        end else begin
            g = CH_UPPER_A + CHAR_W'(d) - 8'd10;
        end
        return g;
    endfunction

endpackage
`default_nettype wire

// ----- src/text_cell_format_printer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// text_cell_format_printer - format string bytes to text-mode cell writes
// parses ordinary bytes, colour directives and %h / %i numbers into cells
// ----------------------------------------------------------------------------
// timing: a plain byte is parsed after its beat and its cell is registered on the
//   output; a start byte first waits for the bit-serial row times stride multiply
// throughput: a new byte is taken only once the printer is back in idle; %i waits
//   for the double dabble, both %h and %i for the leading zero skip, then one
//   digit per cycle while the output does not stall
// reset: synchronous active low; position, colours and parse mode return to
//   row 0, column 0, white on black, plain text; no clearing pass
module text_cell_format_printer
    import tcfp_pkg::*;
#(
    parameter int ROW_STRIDE = 80
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [CHAR_W-1:0]   i_symbol,
    input  wire logic [ARG_W-1:0]    i_arg_value,
    input  wire logic                i_first,
    input  wire logic [POS_W-1:0]    i_start_row,
    input  wire logic [POS_W-1:0]    i_start_col,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [OFFSET_W-1:0]      o_cell_offset,
    output logic [15:0]              o_cell_word,
    output logic                     o_last_of_run
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_PARSE = 6'b000100,
        S_PFX0  = 6'b001000,
        S_PFX1  = 6'b010000,
        S_NUM   = 6'b100000
    } t_state;

    typedef enum logic [4:0] {
        M_NORMAL   = 5'b00001,
        M_PCT      = 5'b00010,
        M_PCT_C    = 5'b00100,
        M_SET_TEXT = 5'b01000,
        M_SET_BACK = 5'b10000
    } t_mode;

    t_state                r_state, n_state;
    t_mode                 r_mode, n_mode;
    logic [COLOUR_W-1:0]   r_text, n_text;
    logic [COLOUR_W-1:0]   r_back, n_back;
    logic [POS_W-1:0]      r_row, n_row;
    logic [POS_W-1:0]      r_col, n_col;
    logic [OFFSET_W-1:0]   r_base, n_base;
    logic [CHAR_W-1:0]     r_sym, n_sym;
    logic [ARG_W-1:0]      r_arg, n_arg;
    logic                  r_out_valid, n_out_valid;
    logic [OFFSET_W-1:0]   r_out_offset, n_out_offset;
    logic [15:0]           r_out_word, n_out_word;
    logic                  r_out_last, n_out_last;

    logic                  in_accept;
    logic                  out_free;
    logic                  emit_en;
    logic                  emit_char_move;
    logic                  emit_last;
    logic [CHAR_W-1:0]     emit_ch;
    logic                  mul_busy;
    logic [OFFSET_W-1:0]   mul_product;
    t_conv_ctl             conv_ctl;
    t_conv_st              conv_st;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    tcfp_rowmul #(
        .ROW_STRIDE (ROW_STRIDE)
    ) u_rowmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_accept && i_first),
        .i_row     (i_start_row),
        .o_busy    (mul_busy),
        .o_product (mul_product)
    );

    tcfp_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (conv_ctl),
        .i_value (r_arg),
        .o_st    (conv_st)
    );

    always_comb begin
        n_state        = r_state;
        n_mode         = r_mode;
        n_text         = r_text;
        n_back         = r_back;
        n_row          = r_row;
        n_col          = r_col;
        n_base         = r_base;
        n_sym          = r_sym;
        n_arg          = r_arg;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_offset   = r_out_offset;
        n_out_word     = r_out_word;
        n_out_last     = r_out_last;
        emit_en        = 1'b0;
        emit_char_move = 1'b0;
        emit_last      = 1'b1;
        emit_ch        = r_sym;
        conv_ctl       = '0;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_sym = i_symbol;
                    n_arg = i_arg_value;
                    if (i_first) begin
                        n_row   = i_start_row;
                        n_col   = i_start_col;
                        n_text  = TEXT_RST;
                        n_back  = BACK_RST;
                        n_mode  = M_NORMAL;
                        n_state = S_MUL;
                    end else begin
                        n_state = S_PARSE;
                    end
                end
            end
            S_MUL: begin
                if (!mul_busy) begin
                    n_base  = mul_product;
                    n_state = S_PARSE;
                end
            end
            S_PARSE: begin
                if (r_sym == CH_NUL) begin
                    n_state = S_IDLE;
                end else begin
                    case (r_mode)
                        M_PCT: begin
                            if (r_sym == CH_C) begin
                                n_mode  = M_PCT_C;
                                n_state = S_IDLE;
                            end else if (r_sym == CH_H) begin
                                n_mode         = M_NORMAL;
                                conv_ctl.start = 1'b1;
                                conv_ctl.hex   = 1'b1;
                                n_state        = S_PFX0;
                            end else if (r_sym == CH_I) begin
                                n_mode         = M_NORMAL;
                                conv_ctl.start = 1'b1;
                                n_state        = S_NUM;
                            end else if (r_sym == CH_S) begin
                                n_mode  = M_NORMAL;
                                n_state = S_IDLE;
                            end else if (r_sym == CH_PCT) begin
                                n_state = S_IDLE;
                            end else if (out_free) begin
                                n_mode         = M_NORMAL;
                                emit_en        = 1'b1;
                                emit_char_move = 1'b1;
                                n_state        = S_IDLE;
                            end
                        end
                        M_PCT_C: begin
                            if (r_sym == CH_T) begin
                                n_mode  = M_SET_TEXT;
                                n_state = S_IDLE;
                            end else if (r_sym == CH_B) begin
                                n_mode  = M_SET_BACK;
                                n_state = S_IDLE;
                            end else if (r_sym == CH_PCT) begin
                                n_mode  = M_PCT;
                                n_state = S_IDLE;
                            end else if (out_free) begin
                                n_mode         = M_NORMAL;
                                emit_en        = 1'b1;
                                emit_char_move = 1'b1;
                                n_state        = S_IDLE;
                            end
                        end
                        M_SET_TEXT: begin
                            n_text  = r_sym[COLOUR_W-1:0];
                            n_mode  = M_NORMAL;
                            n_state = S_IDLE;
                        end
                        M_SET_BACK: begin
                            n_back  = r_sym[COLOUR_W-1:0];
                            n_mode  = M_NORMAL;
                            n_state = S_IDLE;
                        end
                        default: begin
                            if (r_sym == CH_PCT) begin
                                n_mode  = M_PCT;
                                n_state = S_IDLE;
                            end else if (out_free) begin
                                n_mode         = M_NORMAL;
                                emit_en        = 1'b1;
                                emit_char_move = 1'b1;
                                n_state        = S_IDLE;
                            end
                        end
                    endcase
                end
            end
            S_PFX0: begin
                if (out_free) begin
                    emit_en   = 1'b1;
                    emit_ch   = CH_ZERO;
                    emit_last = 1'b0;
                    n_state   = S_PFX1;
                end
            end
            S_PFX1: begin
                if (out_free) begin
                    emit_en   = 1'b1;
                    emit_ch   = CH_X;
                    emit_last = 1'b0;
                    n_state   = S_NUM;
                end
            end
            S_NUM: begin
                if (conv_st.valid && out_free) begin
                    emit_en       = 1'b1;
                    emit_ch       = f_glyph(conv_st.digit);
                    emit_last     = conv_st.last;
                    conv_ctl.take = 1'b1;
                    if (conv_st.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (emit_en) begin
            n_out_valid  = 1'b1;
            n_out_offset = r_base + OFFSET_W'(r_col);
            n_out_word   = {r_back, r_text, emit_ch};
            n_out_last   = emit_last;
            // ordinary characters wrap to row zero once the row reaches the limit
            if (emit_char_move && r_row >= WRAP_ROW) begin
                n_row  = '0;
                n_base = '0;
                n_col  = r_col + POS_W'(1);
            end else begin
                n_col  = r_col + POS_W'(2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= M_NORMAL;
            r_text      <= TEXT_RST;
            r_back      <= BACK_RST;
            r_row       <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_text      <= n_text;
            r_back      <= n_back;
            r_row       <= n_row;
            r_col       <= n_col;
            r_base      <= n_base;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym        <= n_sym;
        r_arg        <= n_arg;
        r_out_offset <= n_out_offset;
        r_out_word   <= n_out_word;
        r_out_last   <= n_out_last;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cell_offset = r_out_offset;
    assign o_cell_word   = r_out_word;
    assign o_last_of_run = r_out_last;

    a_mul_only_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_busy |-> r_state == S_MUL)
        else $error("row multiply running outside its wait state");

    a_first_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_first) |=> (r_state == S_MUL && mul_busy))
        else $error("start beat did not launch the row multiply");

    a_idle_conv_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !conv_st.valid)
        else $error("digits left over after the run ended");

endmodule
`default_nettype wire

// ----- src/tcfp_rowmul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcfp_rowmul - bit-serial row times stride multiplier
// one row bit per cycle, msb first, shift and add into a 23-bit accumulator
// ----------------------------------------------------------------------------
module tcfp_rowmul
    import tcfp_pkg::*;
#(
    parameter int ROW_STRIDE = 80
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [POS_W-1:0]    i_row,
    output logic                     o_busy,
    output logic [OFFSET_W-1:0]      o_product
);

    localparam logic [OFFSET_W-1:0] STRIDE_EXT = OFFSET_W'(ROW_STRIDE);
    localparam int CNT_W = $clog2(POS_W);

    typedef enum logic [1:0] {
        R_IDLE = 2'b01,
        R_RUN  = 2'b10
    } t_rstate;

    t_rstate               r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [POS_W-1:0]      r_row, n_row;
    logic [OFFSET_W-1:0]   r_acc, n_acc;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_row   = r_row;
        n_acc   = r_acc;
        case (r_state)
            R_IDLE: begin
                if (i_start) begin
                    n_state = R_RUN;
                    n_cnt   = CNT_W'(POS_W - 1);
                    n_row   = i_row;
                    n_acc   = '0;
                end
            end
            R_RUN: begin
                n_acc = {r_acc[OFFSET_W-2:0], 1'b0} + (r_row[POS_W-1] ? STRIDE_EXT : '0);
                n_row = {r_row[POS_W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = R_IDLE;
                end
            end
            default: n_state = R_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_row <= n_row;
        r_acc <= n_acc;
    end

    assign o_busy    = (r_state == R_RUN);
    assign o_product = r_acc;

endmodule
`default_nettype wire

// ----- src/tcfp_conv.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcfp_conv - number to digit converter
// bit-serial double dabble for decimal, direct nibble load for hex, then
// leading zeros dropped and digits handed out msb first one per beat
// ----------------------------------------------------------------------------
module tcfp_conv
    import tcfp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_conv_ctl         i_ctl,
    input  wire logic [ARG_W-1:0]  i_value,
    output t_conv_st               o_st
);

    localparam int SHIFT_CNT_W = $clog2(ARG_W);
    localparam int LEFT_W      = $clog2(NUM_DIGITS + 1);

    typedef enum logic [3:0] {
        C_IDLE  = 4'b0001,
        C_SHIFT = 4'b0010,
        C_SKIP  = 4'b0100,
        C_EMIT  = 4'b1000
    } t_cstate;

    t_cstate                 r_state, n_state;
    logic [ARG_W-1:0]        r_bin, n_bin;
    logic [BCD_W-1:0]        r_bcd, n_bcd;
    logic [SHIFT_CNT_W-1:0]  r_cnt, n_cnt;
    logic [LEFT_W-1:0]       r_left, n_left;
    logic                    r_hex, n_hex;
    logic [BCD_W-1:0]        adj;
    logic [DIGIT_W-1:0]      top_digit;

    // add three to every bcd digit of five or more before the shift
    always_comb begin
        for (int g = 0; g < NUM_DIGITS; g++) begin
            if (r_bcd[g*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                adj[g*DIGIT_W +: DIGIT_W] = r_bcd[g*DIGIT_W +: DIGIT_W] + 4'd3;
            end else begin
                adj[g*DIGIT_W +: DIGIT_W] = r_bcd[g*DIGIT_W +: DIGIT_W];
            end
        end
    end

    assign top_digit = r_bcd[BCD_W-1 -: DIGIT_W];

    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_left  = r_left;
        n_hex   = r_hex;
        case (r_state)
            C_IDLE: begin
                if (i_ctl.start) begin
                    n_hex = i_ctl.hex;
                    if (i_ctl.hex) begin
                        n_bcd   = BCD_W'(i_value);
                        n_left  = LEFT_W'(NUM_DIGITS);
                        n_state = C_SKIP;
                    end else begin
                        n_bin   = i_value;
                        n_bcd   = '0;
                        n_cnt   = SHIFT_CNT_W'(ARG_W - 1);
                        n_state = C_SHIFT;
                    end
                end
            end
            C_SHIFT: begin
                n_bcd = {adj[BCD_W-2:0], r_bin[ARG_W-1]};
                n_bin = {r_bin[ARG_W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_left  = LEFT_W'(NUM_DIGITS);
                    n_state = C_SKIP;
                end
            end
            C_SKIP: begin
                // the units digit is always shown
                if (top_digit == '0 && r_left != LEFT_W'(1)) begin
                    n_bcd  = {r_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    n_left = r_left - 1'b1;
                end else begin
                    n_state = C_EMIT;
                end
            end
            C_EMIT: begin
                if (i_ctl.take) begin
                    n_bcd  = {r_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    n_left = r_left - 1'b1;
                    if (r_left == LEFT_W'(1)) begin
                        n_state = C_IDLE;
                    end
                end
            end
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_left <= n_left;
        r_hex  <= n_hex;
    end

    assign o_st.valid = (r_state == C_EMIT);
    assign o_st.digit = top_digit;
    assign o_st.last  = (r_left == LEFT_W'(1));

    a_take_when_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.take |-> r_state == C_EMIT)
        else $error("digit taken while none offered");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> r_state == C_IDLE)
        else $error("conversion started while busy");

    a_decimal_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_EMIT && !r_hex) |-> top_digit <= 4'd9)
        else $error("decimal digit out of range");

endmodule
`default_nettype wire

// ----- tb/sv/tb_text_cell_format_printer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_cell_format_printer - self-checking bench for the format printer
// sends format bytes in random bursts while the cell side stalls on its own
// pattern. every accepted cell is compared with a cycle-free prediction
// ----------------------------------------------------------------------------
module tb_text_cell_format_printer;
    import tcfp_pkg::*;

    localparam int ROW_STRIDE  = 80;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 80;
    localparam int RANDOM_BEATS = 180;

    typedef enum logic [2:0] {
        PM_TEXT,
        PM_PCT,
        PM_PCT_C,
        PM_SET_TEXT,
        PM_SET_BACK
    } t_parse_mode;

    typedef struct packed {
        logic [CHAR_W-1:0] sym;
        logic [ARG_W-1:0]  arg;
        logic              first;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
    } t_beat;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [15:0]         word;
        logic                last;
    } t_cell;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [CHAR_W-1:0]   i_symbol = '0;
    logic [ARG_W-1:0]    i_arg_value = '0;
    logic                i_first = 1'b0;
    logic [POS_W-1:0]    i_start_row = '0;
    logic [POS_W-1:0]    i_start_col = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [OFFSET_W-1:0] o_cell_offset;
    logic [15:0]         o_cell_word;
    logic                o_last_of_run;

    text_cell_format_printer #(
        .ROW_STRIDE(ROW_STRIDE)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_symbol      (i_symbol),
        .i_arg_value   (i_arg_value),
        .i_first       (i_first),
        .i_start_row   (i_start_row),
        .i_start_col   (i_start_col),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_cell_offset (o_cell_offset),
        .o_cell_word   (o_cell_word),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // printer state as the bench sees it
    // ------------------------------------------------------------------
    t_parse_mode         pm = PM_TEXT;
    logic [COLOUR_W-1:0] fg_colour = TEXT_RST;
    logic [COLOUR_W-1:0] bg_colour = BACK_RST;
    logic [POS_W-1:0]    pos_row = '0;
    logic [POS_W-1:0]    pos_col = '0;

    t_beat bytes_to_send[$];
    t_cell cell_run[$];
    t_cell cells_due[$];
    int    errors = 0;
    int    text_beats = 0;

    localparam string HEX_GLYPHS = "0123456789ABCDEF";

    task automatic place_cell(input logic [CHAR_W-1:0] ch, input bit is_digit);
        int    lin;
        t_cell c;
        lin = int'(pos_row) * ROW_STRIDE + int'(pos_col);
        c.offset = lin[OFFSET_W-1:0];
        c.word   = {bg_colour, fg_colour, ch};
        c.last   = 1'b0;
        cell_run.push_back(c);
        // digits never test the row
        if (!is_digit && pos_row >= WRAP_ROW) begin
            pos_row = '0;
            pos_col = pos_col + 16'd1;
        end else begin
            pos_col = pos_col + 16'd2;
        end
    endtask

    task automatic place_number(input logic [ARG_W-1:0] value, input logic [ARG_W-1:0] base);
        logic [CHAR_W-1:0] glyphs[$];
        logic [ARG_W-1:0]  v;
        int                d;
        v = value;
        do begin
            d = int'(v % base);
            glyphs.push_front(HEX_GLYPHS[d]);
            v = v / base;
        end while (v != 0);
        foreach (glyphs[k]) place_cell(glyphs[k], 1'b1);
    endtask

    // work out the cells one format byte gives and queue them
    task automatic format_symbol(input t_beat b);
        cell_run.delete();
        if (b.first) begin
            pos_row   = b.row;
            pos_col   = b.col;
            fg_colour = TEXT_RST;
            bg_colour = BACK_RST;
            pm        = PM_TEXT;
        end
        if (b.sym != CH_NUL) begin
            case (pm)
                PM_PCT: begin
                    pm = PM_TEXT;
                    if (b.sym == CH_C) begin
                        pm = PM_PCT_C;
                    end else if (b.sym == CH_H) begin
                        place_cell(CH_ZERO, 1'b1);
                        place_cell(CH_X, 1'b1);
                        place_number(b.arg, 32'd16);
                    end else if (b.sym == CH_I) begin
                        place_number(b.arg, 32'd10);
                    end else if (b.sym == CH_S) begin
                        pm = PM_TEXT;
                    end else if (b.sym == CH_PCT) begin
                        pm = PM_PCT;
                    end else begin
                        place_cell(b.sym, 1'b0);
                    end
                end
                PM_PCT_C: begin
                    if (b.sym == CH_T) begin
                        pm = PM_SET_TEXT;
                    end else if (b.sym == CH_B) begin
                        pm = PM_SET_BACK;
                    end else if (b.sym == CH_PCT) begin
                        pm = PM_PCT;
                    end else begin
                        pm = PM_TEXT;
                        place_cell(b.sym, 1'b0);
                    end
                end
                PM_SET_TEXT: begin
                    fg_colour = b.sym[COLOUR_W-1:0];
                    pm = PM_TEXT;
                end
                PM_SET_BACK: begin
                    bg_colour = b.sym[COLOUR_W-1:0];
                    pm = PM_TEXT;
                end
                default: begin
                    pm = PM_TEXT;
                    if (b.sym == CH_PCT) begin
                        pm = PM_PCT;
                    end else begin
                        place_cell(b.sym, 1'b0);
                    end
                end
            endcase
        end
        if (cell_run.size() > 0) begin
            cell_run[cell_run.size()-1].last = 1'b1;
            foreach (cell_run[k]) cells_due.push_back(cell_run[k]);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_beat(input logic [CHAR_W-1:0] sym, input logic [ARG_W-1:0] arg,
                              input logic first, input logic [POS_W-1:0] row,
                              input logic [POS_W-1:0] col);
        t_beat b;
        b = '{sym, arg, first, row, col};
        bytes_to_send.push_back(b);
        if (sym != CH_NUL) text_beats++;
    endtask

    function automatic logic [POS_W-1:0] pick_row();
        logic [POS_W-1:0] r;
        case ($urandom_range(0, 3))
            0:       r = POS_W'($urandom_range(0, 79));
            1:       r = POS_W'($urandom_range(76, 84));
            2:       r = POS_W'($urandom);
            default: r = 16'hFFFF - POS_W'($urandom_range(0, 2));
        endcase
        return r;
    endfunction

    function automatic logic [POS_W-1:0] pick_col();
        logic [POS_W-1:0] c;
        case ($urandom_range(0, 2))
            0:       c = POS_W'($urandom_range(0, 160));
            1:       c = 16'hFFFF - POS_W'($urandom_range(0, 20));
            default: c = POS_W'($urandom);
        endcase
        return c;
    endfunction

    function automatic logic [ARG_W-1:0] pick_arg();
        logic [ARG_W-1:0] a;
        case ($urandom_range(0, 5))
            0:       a = '0;
            1:       a = '1;
            2:       a = ARG_W'($urandom_range(0, 20));
            3:       a = $urandom;
            default: a = $urandom >> $urandom_range(1, 31);
        endcase
        return a;
    endfunction

    // plain byte with random junk on the unused fields
    task automatic queue_sym(input logic [CHAR_W-1:0] sym, input logic [ARG_W-1:0] arg);
        queue_beat(sym, arg, 1'b0, POS_W'($urandom), POS_W'($urandom));
    endtask

    task automatic queue_lead(input logic [CHAR_W-1:0] sym);
        queue_beat(sym, $urandom, ($urandom_range(0, 15) == 0), pick_row(), pick_col());
    endtask

    function automatic logic [CHAR_W-1:0] pick_plain();
        logic [CHAR_W-1:0] s;
        do s = CHAR_W'($urandom_range(1, 255)); while (s == CH_PCT);
        return s;
    endfunction

    task automatic queue_random_sequence();
        int k;
        logic [CHAR_W-1:0] s;
        k = $urandom_range(0, 99);
        if (k < 28) begin
            queue_lead(pick_plain());
        end else if (k < 42) begin
            queue_lead(CH_PCT);
            queue_sym(CH_H, pick_arg());
        end else if (k < 56) begin
            queue_lead(CH_PCT);
            queue_sym(CH_I, pick_arg());
        end else if (k < 64) begin
            queue_lead(CH_PCT);
            queue_sym(CH_C, $urandom);
            queue_sym(CH_T, $urandom);
            queue_sym(CHAR_W'($urandom_range(0, 255)), $urandom);
        end else if (k < 72) begin
            queue_lead(CH_PCT);
            queue_sym(CH_C, $urandom);
            queue_sym(CH_B, $urandom);
            queue_sym(CHAR_W'($urandom_range(0, 255)), $urandom);
        end else if (k < 75) begin
            queue_lead(CH_PCT);
            queue_sym(CH_S, $urandom);
        end else if (k < 79) begin
            // unknown directive letter
            queue_lead(CH_PCT);
            do s = pick_plain(); while (s == CH_C || s == CH_H || s == CH_I || s == CH_S);
            queue_sym(s, $urandom);
        end else if (k < 83) begin
            queue_lead(CH_PCT);
            queue_sym(CH_PCT, $urandom);
            queue_sym(($urandom_range(0, 1) != 0) ? CH_H : CH_I, pick_arg());
        end else if (k < 87) begin
            // colour prefix followed by something else
            queue_lead(CH_PCT);
            queue_sym(CH_C, $urandom);
            do s = pick_plain(); while (s == CH_T || s == CH_B);
            queue_sym(s, $urandom);
        end else if (k < 90) begin
            queue_lead(CH_PCT);
            queue_sym(CH_C, $urandom);
            queue_sym(CH_PCT, $urandom);
            queue_sym(CH_I, pick_arg());
        end else if (k < 94) begin
            queue_beat(CH_NUL, $urandom, ($urandom_range(0, 1) != 0), pick_row(), pick_col());
        end else if (k < 97) begin
            queue_beat(CHAR_W'($urandom_range(1, 255)), $urandom, 1'b1, pick_row(), pick_col());
        end else begin
            queue_sym(CHAR_W'($urandom), $urandom);
        end
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of beats with random gaps
    // ------------------------------------------------------------------
    t_beat held;
    int    burst_left = 1;
    int    gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) format_symbol(held);
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (bytes_to_send.size() > 0) begin
                    held = bytes_to_send.pop_front();
                    i_in_valid  <= 1'b1;
                    i_symbol    <= held.sym;
                    i_arg_value <= held.arg;
                    i_first     <= held.first;
                    i_start_row <= held.row;
                    i_start_col <= held.col;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // cell side stall pattern: free, coin toss, or long holds
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int stall_left = 0;
    int stall_phase = 0;

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(10, 80);
        end else begin
            stall_left--;
        end
        stall_phase = (stall_phase + 1) % 24;
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 1) != 0);
            default: i_out_stall <= (stall_phase < 18);
        endcase
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : cell_monitor
        t_cell got;
        t_cell want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_cell_offset, o_cell_word, o_last_of_run};
            if (cells_due.size() == 0) begin
                $display("%0t: unexpected cell offset %0d word %h last %0b",
                         $realtime, got.offset, got.word, got.last);
                errors++;
            end else begin
                want = cells_due.pop_front();
                if (got !== want) begin
                    $display("%0t: expected %0d %h %0b, actual %0d %h %0b",
                             $realtime, want.offset, want.word, want.last,
                             got.offset, got.word, got.last);
                    errors++;
                end
            end
        end
    end

    int cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_text_cell_format_printer failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        // plain text from the origin
        queue_beat("A", '0, 1'b1, 16'd0, 16'd0);
        queue_sym("z", '1);
        // zero byte with a new start, then a high character at the column wrap
        queue_beat(CH_NUL, '1, 1'b1, 16'd79, 16'hFFFE);
        queue_sym(8'hFF, '0);
        // row past the wrap: hex run keeps the row, the text byte wraps it
        queue_beat(CH_PCT, '0, 1'b1, 16'd80, 16'd10);
        queue_sym(CH_H, 32'hFFFF_FFFF);
        queue_sym("C", '0);
        queue_sym(CH_PCT, '0);
        queue_sym(CH_I, 32'hFFFF_FFFF);
        // colour byte taken even when it is a percent
        queue_sym(CH_PCT, '0);
        queue_sym(CH_C, '0);
        queue_sym(CH_T, '0);
        queue_sym(CH_PCT, '0);
        queue_sym(CH_PCT, '0);
        queue_sym(CH_C, '0);
        queue_sym(CH_B, '0);
        queue_sym(8'hFF, '0);
        // doubled percent keeps directive mode
        queue_sym(CH_PCT, '0);
        queue_sym(CH_PCT, '0);
        queue_sym(CH_H, '0);
        queue_sym(CH_PCT, '0);
        queue_sym(CH_S, '0);
        queue_sym(CH_PCT, '0);
        queue_sym("q", '0);
        queue_sym(CH_PCT, '0);
        queue_sym(CH_C, '0);
        queue_sym("x", '0);
        queue_sym(CH_PCT, '0);
        queue_sym(CH_C, '0);
        queue_sym(CH_PCT, '0);
        queue_sym(CH_I, '0);
        queue_beat("Q", '0, 1'b1, 16'hFFFF, 16'hFFFF);

        while (text_beats < RANDOM_BEATS) queue_random_sequence();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_to_send.size() != 0 || i_in_valid) @(negedge i_clk);
        while (cells_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (errors == 0 && cells_due.size() == 0) begin
            $display("tb_text_cell_format_printer passed");
        end else begin
            $display("tb_text_cell_format_printer failed");
        end
        $finish;
    end

endmodule
